@@ sv/vet_pkg.sv @@
package vet_pkg;

  localparam int VOTERS = 256;
  localparam int IDX_W = $clog2(VOTERS);
  localparam int VOTER_W = 8;
  localparam int DIGEST_W = 64;
  localparam int WEIGHT_W = 32;
  localparam int SUM_W = 40;
  localparam int STATUS_W = 3;
  localparam int IN_DATA_W = VOTER_W + DIGEST_W + WEIGHT_W;
  localparam int OUT_DATA_W = SUM_W;

  typedef enum logic [1:0] {
    TAG_EMPTY  = 2'd0,
    TAG_SINGLE = 2'd1,
    TAG_EQUIV  = 2'd2
  } tag_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED    = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_EQUIVOCATED = 3'd2,
    ST_WITHDRAWN   = 3'd3,
    ST_IGNORED     = 3'd4
  } status_t;

  typedef enum logic {
    KIND_PUSH     = 1'b0,
    KIND_WITHDRAW = 1'b1
  } kind_t;

endpackage

@@ sv/vote_equivocation_tracker.sv @@
// Tracks one vote per voter and flags equivocation. Each input beat (push or withdraw of a
// vote digest for a voter) yields exactly one output beat carrying a status code and the
// running total weight after that beat, modulo two to the forty. One beat is accepted every
// clock cycle while the output is taken; its result reaches the master side when the beat moves
// on to the output register, and the accepting edge registers the beat together with a read
// of the digest and tag tables, and the compare and update of the voter's entry and the total
// settle before the next edge, with a forwarding path so that back-to-back beats to the same
// voter see each other's writes. A stalled output holds one beat in the output register and
// one in the input register, after which s_tready falls. A flag per voter, cleared by reset,
// marks the entries written since reset, so the block is ready straight after reset with no
// clearing pass. The table depth is a power of two and the voter index is taken modulo that
// depth.
module vote_equivocation_tracker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // voter_index [7:0], vote_digest [71:8], weight [103:72]
  input  logic [vet_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind [0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // weight_sum [39:0]
  output logic [vet_pkg::OUT_DATA_W-1:0] m_tdata,
  // status [2:0]
  output logic [vet_pkg::STATUS_W-1:0]   m_tuser
);
  import vet_pkg::*;

  logic [DIGEST_W-1:0] mem [VOTERS];
  tag_t                tags [VOTERS];
  logic [VOTERS-1:0]   written;

  logic                s1_valid;
  kind_t               s1_kind;
  logic [IDX_W-1:0]    s1_idx;
  logic [DIGEST_W-1:0] s1_digest;
  logic [WEIGHT_W-1:0] s1_weight;
  logic [DIGEST_W-1:0] mem_q;
  logic                fwd_hit;
  logic [DIGEST_W-1:0] fwd_data;
  tag_t                tag_q;
  logic                tag_fwd_hit;
  tag_t                tag_fwd_data;

  logic [SUM_W-1:0]    total;
  logic [SUM_W-1:0]    total_next;
  tag_t                tag_next;
  status_t             status_next;
  logic                wr_en;
  logic                tag_wr;

  logic                accept;
  logic                adv;
  logic [IDX_W-1:0]    in_idx;
  tag_t                cur_tag;
  logic [DIGEST_W-1:0] stored;
  logic                match;

  assign in_idx   = s_tdata[IDX_W-1:0];
  assign adv      = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || adv;
  assign accept   = s_tvalid && s_tready;

  assign cur_tag = tag_fwd_hit ? tag_fwd_data : (written[s1_idx] ? tag_q : TAG_EMPTY);
  assign stored  = fwd_hit ? fwd_data : mem_q;
  assign match   = (stored == s1_digest);

  always_comb begin
    total_next  = total;
    tag_next    = cur_tag;
    status_next = ST_IGNORED;
    wr_en       = 1'b0;
    tag_wr      = 1'b0;
    if (s1_kind == KIND_PUSH) begin
      case (cur_tag)
        TAG_SINGLE: begin
          if (match) begin
            status_next = ST_DUPLICATE;
          end else begin
            status_next = ST_EQUIVOCATED;
            tag_next    = TAG_EQUIV;
            tag_wr      = adv;
          end
        end
        TAG_EQUIV: begin
          status_next = ST_EQUIVOCATED;
        end
        default: begin
          status_next = ST_ACCEPTED;
          tag_next    = TAG_SINGLE;
          tag_wr      = adv;
          wr_en       = adv;
          total_next  = total + SUM_W'(s1_weight);
        end
      endcase
    end else begin
      if (cur_tag == TAG_SINGLE && match) begin
        status_next = ST_WITHDRAWN;
        tag_next    = TAG_EMPTY;
        tag_wr      = adv;
        total_next  = total - SUM_W'(s1_weight);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx] <= s1_digest;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_wr) begin
      tags[s1_idx] <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mem_q <= mem[in_idx];
      tag_q <= tags[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind      <= kind_t'(s_tuser);
      s1_idx       <= in_idx;
      s1_digest    <= s_tdata[VOTER_W +: DIGEST_W];
      s1_weight    <= s_tdata[VOTER_W + DIGEST_W +: WEIGHT_W];
      fwd_hit      <= wr_en && (s1_idx == in_idx);
      fwd_data     <= s1_digest;
      tag_fwd_hit  <= tag_wr && (s1_idx == in_idx);
      tag_fwd_data <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (tag_wr) begin
      written[s1_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      total    <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv) begin
        m_tvalid <= 1'b1;
        total    <= total_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= total_next;
      m_tuser <= status_next;
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import vet_pkg::*;

  class VoteLedger;
    tag_t                slot_tag[VOTERS];
    logic [DIGEST_W-1:0] slot_digest[VOTERS];
    logic [SUM_W-1:0]    weight_total;
    status_t             awaited_status[$];
    logic [SUM_W-1:0]    awaited_total[$];
    int                  errors;

    function new();
      foreach (slot_tag[i]) begin
        slot_tag[i] = TAG_EMPTY;
        slot_digest[i] = '0;
      end
      weight_total = '0;
      errors = 0;
    endfunction

    function int pending();
      return awaited_status.size();
    endfunction

    function void log_awaited(status_t st, logic [SUM_W-1:0] sum);
      awaited_status = {awaited_status, st};
      awaited_total = {awaited_total, sum};
    endfunction

    function void note_beat(kind_t k, logic [VOTER_W-1:0] idx, logic [DIGEST_W-1:0] dg,
                            logic [WEIGHT_W-1:0] w);
      status_t st;
      int      s;
      s = idx % VOTERS;
      if (k == KIND_PUSH) begin
        if (slot_tag[s] == TAG_SINGLE) begin
          if (slot_digest[s] == dg) begin
            st = ST_DUPLICATE;
          end else begin
            slot_tag[s] = TAG_EQUIV;
            st = ST_EQUIVOCATED;
          end
        end else if (slot_tag[s] == TAG_EQUIV) begin
          st = ST_EQUIVOCATED;
        end else begin
          slot_tag[s] = TAG_SINGLE;
          slot_digest[s] = dg;
          weight_total = weight_total + {{(SUM_W-WEIGHT_W){1'b0}}, w};
          st = ST_ACCEPTED;
        end
      end else begin
        if (slot_tag[s] == TAG_SINGLE && slot_digest[s] == dg) begin
          slot_tag[s] = TAG_EMPTY;
          weight_total = weight_total - {{(SUM_W-WEIGHT_W){1'b0}}, w};
          st = ST_WITHDRAWN;
        end else begin
          st = ST_IGNORED;
        end
      end
      log_awaited(st, weight_total);
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(input logic [STATUS_W-1:0] st, input logic [SUM_W-1:0] sum);
      status_t          want_st;
      logic [SUM_W-1:0] want_sum;
      if (awaited_status.size() == 0) begin
        report($sformatf("unexpected beat, status %0d total %h", st, sum));
      end else begin
        want_st = awaited_status.pop_front();
        want_sum = awaited_total.pop_front();
        if (st !== want_st)
          report($sformatf("status %0d, expected %0d (%s)", st, want_st, want_st.name()));
        if (sum !== want_sum)
          report($sformatf("weight total %h, expected %h", sum, want_sum));
      end
    endtask
  endclass

  localparam int STALL_LIMIT = 1000;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0]   m_tuser;

  VoteLedger           ledger;
  int                  send_idle_pct;
  int                  recv_idle_pct;
  int                  quiet_cycles;
  int                  last_idx;
  logic [DIGEST_W-1:0] digest_pool[4];

  vote_equivocation_tracker DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        ledger.note_beat(kind_t'(s_tuser), s_tdata[7:0], s_tdata[71:8], s_tdata[103:72]);
      if (m_tvalid && m_tready)
        ledger.check_result(m_tuser, m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(input kind_t k, input logic [VOTER_W-1:0] idx,
                           input logic [DIGEST_W-1:0] dg, input logic [WEIGHT_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = k;
    s_tdata = {w, dg, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    s_tvalid = 1'b0;
    while (ledger.pending() > 0) @(negedge clk);
  endtask

  task automatic random_beat();
    kind_t               k;
    int                  idx;
    int                  r;
    logic [DIGEST_W-1:0] dg;
    logic [WEIGHT_W-1:0] w;
    r = $urandom_range(9);
    if (r < 2)
      idx = last_idx;
    else if (r < 6)
      idx = $urandom_range(7);
    else
      idx = $urandom_range(255);
    last_idx = idx;
    k = ($urandom_range(99) < 45) ? KIND_WITHDRAW : KIND_PUSH;
    r = $urandom_range(9);
    if (r < 4)
      dg = ledger.slot_digest[idx];
    else if (r < 8)
      dg = digest_pool[$urandom_range(3)];
    else
      dg = {$urandom, $urandom};
    r = $urandom_range(9);
    if (r == 0)
      w = '0;
    else if (r == 1)
      w = '1;
    else
      w = $urandom;
    send_beat(k, idx[VOTER_W-1:0], dg, w);
  endtask

  initial begin
    ledger = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    quiet_cycles = 0;
    last_idx = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (digest_pool[i]) digest_pool[i] = {$urandom, $urandom};
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Back-to-back beats to the same voter, then wrap-around of the total both ways.
    send_beat(KIND_PUSH, 8'd0, 64'd0, 32'hFFFF_FFFF);
    send_beat(KIND_PUSH, 8'd0, 64'd0, 32'd5);
    send_beat(KIND_PUSH, 8'd0, '1, 32'd7);
    send_beat(KIND_PUSH, 8'd0, 64'd0, 32'd1);
    send_beat(KIND_WITHDRAW, 8'd0, 64'd0, 32'd1);
    send_beat(KIND_WITHDRAW, 8'd3, 64'd0, 32'd1);
    send_beat(KIND_PUSH, 8'd255, '1, 32'hFFFF_FFFF);
    send_beat(KIND_WITHDRAW, 8'd255, 64'd0, 32'd1);
    send_beat(KIND_WITHDRAW, 8'd255, '1, 32'd1);
    send_beat(KIND_PUSH, 8'd255, 64'h5555_5555_5555_5555, 32'd0);
    send_beat(KIND_WITHDRAW, 8'd255, 64'h5555_5555_5555_5555, 32'hFFFF_FFFF);
    repeat (3) begin
      send_beat(KIND_PUSH, 8'd1, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
      send_beat(KIND_WITHDRAW, 8'd1, 64'hAAAA_AAAA_AAAA_AAAA, 32'hFFFF_FFFF);
    end
    for (int v = 8; v < 11; v++) send_beat(KIND_PUSH, v[7:0], '1, 32'hFFFF_FFFF);

    send_idle_pct = 16;
    recv_idle_pct = 71;
    repeat (500) random_beat();
    hold_until_drained();

    send_idle_pct = 71;
    recv_idle_pct = 16;
    repeat (500) random_beat();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (500) random_beat();

    s_tvalid = 1'b0;
    while (ledger.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/vet_pkg.sv
sv/vote_equivocation_tracker.sv
test/testbench.sv
